[design/u8u2_pkg.sv]
`default_nettype none

package u8u2_pkg;

    // Width of the per-buffer unit counter.
    localparam int COUNT_BITS = 16;

    // Compare width wide enough for both the counter and max_units.
    localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    // Largest value the unit counter can hold.
    localparam logic [CMP_W-1:0] CNT_CAP = CMP_W'((64'd1 << COUNT_BITS) - 64'd1);

    localparam logic [15:0] MAX_UNITS_RESET = 16'hFFFF;

    // Byte boundaries.
    localparam logic [7:0] ASCII_MAX   = 8'h7F;
    localparam logic [7:0] LEAD2_MIN   = 8'hC2;
    localparam logic [7:0] LEAD2_MAX   = 8'hDF;
    localparam logic [7:0] LEAD3_MIN   = 8'hE0;
    localparam logic [7:0] LEAD3_MAX   = 8'hEF;
    localparam logic [7:0] LEAD3_SURR  = 8'hED;
    localparam logic [7:0] CONT_MIN    = 8'h80;
    localparam logic [7:0] CONT_LO_MAX = 8'h9F;
    localparam logic [7:0] CONT_HI_MIN = 8'hA0;
    localparam logic [7:0] CONT_MAX    = 8'hBF;

    // Lead classes of a three-byte sequence.
    localparam logic [1:0] LC_PLAIN = 2'd0;
    localparam logic [1:0] LC_E0    = 2'd1;
    localparam logic [1:0] LC_ED    = 2'd2;

    // Continuation bytes still due.
    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_ONE  = 2'd1;
    localparam logic [1:0] PEND_TWO  = 2'd2;

    typedef struct packed {
        logic       is_ascii;
        logic       is_lead2;
        logic       is_lead3;
        logic [1:0] lead_cls;
        logic       cont_lo;   // 80-9F
        logic       cont_hi;   // A0-BF
    } byte_class_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        final_byte;
        byte_class_t cls;
    } item_t;

    typedef struct packed {
        logic        unit_valid;
        logic [15:0] code_unit;
        logic        done_res;
        logic        status;
        logic [15:0] unit_count;
    } result_t;

endpackage

`default_nettype wire

[design/utf8_to_ucs2_decoder.sv]
// A byte accepted at the input is registered from the classifier into the queue,
//   then decoded into the output register, before its result shows at m_tvalid.
// Throughput: one byte per cycle while m_tready stays high; the decoder
//   output register and the two-entry queue absorb short output stalls.
// Reset: rst_n low clears queue, decoder state and output valid at once;
//   max_units returns to 65535.
`default_nettype none

module utf8_to_ucs2_decoder (
    input  wire logic        clk,
    input  wire logic        rst_n,

    // Configuration: unit capacity of the destination buffer.
    input  wire logic        max_units_we,
    input  wire logic [15:0] max_units_wdata,

    // Byte stream in.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // final_byte

    // Code units out.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [15:0] code_unit, [16] status,
                                        // [32:17] unit_count, [39:33] zero
    output logic             m_tlast,   // done_res
    output logic             m_tuser    // unit_valid
);

    logic [15:0]       max_units_reg;
    u8u2_pkg::item_t   front_item;
    u8u2_pkg::item_t   q_item;
    logic              q_valid;
    logic              q_ready;
    u8u2_pkg::result_t res;

    // Capacity register; the user must write it only between buffers (not enforced here).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_units_reg <= u8u2_pkg::MAX_UNITS_RESET;
        end
        else if (max_units_we)
        begin
            max_units_reg <= max_units_wdata;
        end
    end

    // Front: classify each byte as it arrives (ASCII, lead, continuation range).
    u8u2_front u_front (
        .data_byte  (s_tdata),
        .final_byte (s_tlast),
        .item       (front_item)
    );

    // Short queue so the input side keeps taking transfers while the decoder
    // waits on a stalled output.
    u8u2_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (s_tvalid),
        .push_ready (s_tready),
        .push_item  (front_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    // Back: sequence state, validation, unit limit and status report.
    u8u2_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .max_units  (max_units_reg),
        .in_valid   (q_valid),
        .in_ready   (q_ready),
        .in_item    (q_item),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_res    (res)
    );

    assign m_tdata = {7'b0, res.unit_count, res.status, res.code_unit};
    assign m_tlast = res.done_res;
    assign m_tuser = res.unit_valid;

endmodule

`default_nettype wire

[design/u8u2_front.sv]
`default_nettype none

// Classifies each incoming byte so the decoder only sees ready-made flags.
module u8u2_front (
    input  wire logic [7:0]     data_byte,
    input  wire logic           final_byte,
    output u8u2_pkg::item_t     item
);

    always_comb
    begin
        item.data_byte    = data_byte;
        item.final_byte   = final_byte;
        item.cls.is_ascii = (data_byte <= u8u2_pkg::ASCII_MAX);
        item.cls.is_lead2 = (data_byte >= u8u2_pkg::LEAD2_MIN) &&
                            (data_byte <= u8u2_pkg::LEAD2_MAX);
        item.cls.is_lead3 = (data_byte >= u8u2_pkg::LEAD3_MIN) &&
                            (data_byte <= u8u2_pkg::LEAD3_MAX);
        item.cls.cont_lo  = (data_byte >= u8u2_pkg::CONT_MIN) &&
                            (data_byte <= u8u2_pkg::CONT_LO_MAX);
        item.cls.cont_hi  = (data_byte >= u8u2_pkg::CONT_HI_MIN) &&
                            (data_byte <= u8u2_pkg::CONT_MAX);
        priority if (data_byte == u8u2_pkg::LEAD3_MIN)
        begin
            item.cls.lead_cls = u8u2_pkg::LC_E0;
        end
        else if (data_byte == u8u2_pkg::LEAD3_SURR)
        begin
            item.cls.lead_cls = u8u2_pkg::LC_ED;
        end
        else
        begin
            item.cls.lead_cls = u8u2_pkg::LC_PLAIN;
        end
    end

endmodule

`default_nettype wire

[design/u8u2_queue.sv]
`default_nettype none

// Two-entry queue between classifier and decoder.
module u8u2_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push_valid,
    output logic                 push_ready,
    input  wire u8u2_pkg::item_t push_item,
    output logic                 pop_valid,
    input  wire logic            pop_ready,
    output u8u2_pkg::item_t      pop_item
);

    u8u2_pkg::item_t entry_reg [2];
    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic       do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

[design/u8u2_back.sv]
`default_nettype none

// Sequence decoder with its own output register.
module u8u2_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic [15:0]     max_units,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire u8u2_pkg::item_t in_item,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output u8u2_pkg::result_t    out_res
);

    logic [1:0]                      pend_reg, pend_next;
    logic [1:0]                      lc_reg, lc_next;
    logic [15:0]                     partial_reg, partial_next;
    logic [u8u2_pkg::COUNT_BITS-1:0] units_reg, units_next;
    logic                            disc_reg, disc_next;
    logic                            err_reg, err_next;
    logic                            out_valid_reg;
    u8u2_pkg::result_t               res_reg, res_next;

    logic [u8u2_pkg::CMP_W-1:0] limit;
    logic                       below_limit;
    logic                       emit;
    logic                       cont_ok;
    logic                       pop;
    logic                       bad;
    logic [15:0]                unit;

    assign limit = (u8u2_pkg::CMP_W'(max_units) < u8u2_pkg::CNT_CAP) ?
                   u8u2_pkg::CMP_W'(max_units) : u8u2_pkg::CNT_CAP;
    assign below_limit = (u8u2_pkg::CMP_W'(units_reg) < limit);

    assign in_ready  = !out_valid_reg || out_ready;
    assign pop       = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        pend_next    = pend_reg;
        lc_next      = lc_reg;
        partial_next = partial_reg;
        units_next   = units_reg;
        disc_next    = disc_reg;
        err_next     = err_reg;
        emit         = 1'b0;
        bad          = 1'b0;
        unit         = 16'h0000;

        if ((pend_reg == u8u2_pkg::PEND_TWO) && (lc_reg == u8u2_pkg::LC_E0))
        begin
            cont_ok = in_item.cls.cont_hi;
        end
        else if ((pend_reg == u8u2_pkg::PEND_TWO) && (lc_reg == u8u2_pkg::LC_ED))
        begin
            cont_ok = in_item.cls.cont_lo;
        end
        else
        begin
            cont_ok = in_item.cls.cont_lo || in_item.cls.cont_hi;
        end

        if (!disc_reg)
        begin
            if (pend_reg == u8u2_pkg::PEND_NONE)
            begin
                priority if (!below_limit)
                begin
                    disc_next = 1'b1;
                end
                else if (in_item.cls.is_ascii)
                begin
                    unit = {8'h00, in_item.data_byte};
                    emit = 1'b1;
                end
                else if (in_item.cls.is_lead2)
                begin
                    partial_next = {5'b0, in_item.data_byte[4:0], 6'b0};
                    pend_next    = u8u2_pkg::PEND_ONE;
                    lc_next      = u8u2_pkg::LC_PLAIN;
                end
                else if (in_item.cls.is_lead3)
                begin
                    partial_next = {in_item.data_byte[3:0], 12'h000};
                    pend_next    = u8u2_pkg::PEND_TWO;
                    lc_next      = in_item.cls.lead_cls;
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            else
            begin
                priority if (!cont_ok)
                begin
                    bad = 1'b1;
                end
                else if (pend_reg == u8u2_pkg::PEND_TWO)
                begin
                    partial_next = partial_reg | {4'h0, in_item.data_byte[5:0], 6'b0};
                    pend_next    = u8u2_pkg::PEND_ONE;
                end
                else
                begin
                    unit      = partial_reg | {10'b0, in_item.data_byte[5:0]};
                    pend_next = u8u2_pkg::PEND_NONE;
                    lc_next   = u8u2_pkg::LC_PLAIN;
                    emit      = 1'b1;
                end
            end
        end

        if (emit && below_limit)
        begin
            units_next = units_reg + 1'b1;
        end

        // A buffer that ends inside a sequence counts as truncated.
        if (in_item.final_byte && !disc_next && (pend_next != u8u2_pkg::PEND_NONE))
        begin
            bad = 1'b1;
        end

        if (bad)
        begin
            err_next  = 1'b1;
            disc_next = 1'b1;
            pend_next = u8u2_pkg::PEND_NONE;
            lc_next   = u8u2_pkg::LC_PLAIN;
        end

        res_next.unit_valid = emit;
        res_next.code_unit  = unit;
        res_next.done_res   = in_item.final_byte;
        res_next.status     = in_item.final_byte && err_next;
        res_next.unit_count = in_item.final_byte ? 16'(units_next) : 16'h0000;

        if (in_item.final_byte)
        begin
            pend_next    = u8u2_pkg::PEND_NONE;
            lc_next      = u8u2_pkg::LC_PLAIN;
            partial_next = 16'h0000;
            units_next   = '0;
            disc_next    = 1'b0;
            err_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= u8u2_pkg::PEND_NONE;
            lc_reg        <= u8u2_pkg::LC_PLAIN;
            partial_reg   <= 16'h0000;
            units_reg     <= '0;
            disc_reg      <= 1'b0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                pend_reg      <= pend_next;
                lc_reg        <= lc_next;
                partial_reg   <= partial_next;
                units_reg     <= units_next;
                disc_reg      <= disc_next;
                err_reg       <= err_next;
                out_valid_reg <= emit || in_item.final_byte;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && (emit || in_item.final_byte))
        begin
            res_reg <= res_next;
        end
    end

endmodule

`default_nettype wire
